### rtl/dcwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcwd_pkg;

    // Field widths of the date and result requests.
    localparam int YEAR_W   = 12;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int WDAY_W   = 3;
    localparam int DNUM_W   = 16;

    // Internal widths.
    localparam int CENT_W  = 6;   // year / 100 for a 12-bit year
    localparam int REM_W   = 7;   // year % 100
    localparam int DOY_W   = 9;   // day of year, up to 366
    localparam int ZSUM_W  = 9;   // Zeller sum before mod 7, up to 403
    localparam int YDAYS_W = 21;  // whole-year days past the epoch
    localparam int DN_W    = 22;  // unsaturated day number

    localparam int DEF_EPOCH_YEAR = 1970;
    localparam int DEF_LAST_YEAR  = 2100;

    localparam int MAX_HOUR   = 23;
    localparam int MAX_MINUTE = 59;
    localparam int DAYS_YEAR  = 365;

    // x / 100 == (x * 5243) >> 19, exact for x below 43690
    localparam int RECIP_100   = 5243;
    localparam int RECIP_100_S = 19;
    localparam int RECIP_100_W = YEAR_W + 14;

    // x / 7 == (x * 293) >> 11, exact for 9-bit x
    localparam int RECIP_7   = 293;
    localparam int RECIP_7_S = 11;
    localparam int RECIP_7_W = ZSUM_W + 9;

    typedef enum logic [MONTH_W-1:0] {
        JAN = 4'd1, FEB = 4'd2, MAR = 4'd3, APR = 4'd4, MAY = 4'd5, JUN = 4'd6,
        JUL = 4'd7, AUG = 4'd8, SEP = 4'd9, OCT = 4'd10, NOV = 4'd11, DEC = 4'd12
    } month_t;

    // Stage 1 -> stage 2
    typedef struct packed {
        logic                ok;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [YEAR_W-1:0]   zy;     // year shifted back for Jan/Feb
        logic [CENT_W-1:0]   yq;     // year / 100
        logic [CENT_W-1:0]   zq;     // zy / 100
        logic [CENT_W-1:0]   pq;     // (year - 1) / 100
    } check_t;

    // Stage 2 -> stage 3
    typedef struct packed {
        logic                ok;
        logic [DOY_W-1:0]    doy;
        logic [YDAYS_W-1:0]  ydays;
        logic [ZSUM_W-1:0]   zsum;
    } count_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            FEB:                    len = leap ? 5'd29 : 5'd28;
            APR, JUN, SEP, NOV:     len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // days in the months before m, non-leap year
    function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            JAN:     d = 9'd0;
            FEB:     d = 9'd31;
            MAR:     d = 9'd59;
            APR:     d = 9'd90;
            MAY:     d = 9'd120;
            JUN:     d = 9'd151;
            JUL:     d = 9'd181;
            AUG:     d = 9'd212;
            SEP:     d = 9'd243;
            OCT:     d = 9'd273;
            NOV:     d = 9'd304;
            DEC:     d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // (13 * (zm + 1)) / 5 with Jan/Feb counted as months 13/14
    function automatic logic [5:0] zeller_month(input logic [MONTH_W-1:0] m);
        logic [5:0] z;
        case (m)
            JAN:     z = 6'd36;
            FEB:     z = 6'd39;
            MAR:     z = 6'd10;
            APR:     z = 6'd13;
            MAY:     z = 6'd15;
            JUN:     z = 6'd18;
            JUL:     z = 6'd20;
            AUG:     z = 6'd23;
            SEP:     z = 6'd26;
            OCT:     z = 6'd28;
            NOV:     z = 6'd31;
            DEC:     z = 6'd33;
            default: z = 6'd0;
        endcase
        return z;
    endfunction

endpackage

`default_nettype wire

### rtl/dcwd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface dcwd_date_if;
    logic                          valid;
    logic                          ready;
    logic [dcwd_pkg::YEAR_W-1:0]   year_in;
    logic [dcwd_pkg::MONTH_W-1:0]  month_in;
    logic [dcwd_pkg::DAY_W-1:0]    day_in;
    logic [dcwd_pkg::HOUR_W-1:0]   hour_in;
    logic [dcwd_pkg::MINUTE_W-1:0] minute_in;

    modport source (output valid, year_in, month_in, day_in, hour_in, minute_in,
                    input ready);
    modport sink   (input valid, year_in, month_in, day_in, hour_in, minute_in,
                    output ready);
endinterface

interface dcwd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        date_valid;
    logic [dcwd_pkg::WDAY_W-1:0] weekday;
    logic [dcwd_pkg::DNUM_W-1:0] day_number;

    modport source (output valid, date_valid, weekday, day_number, input ready);
    modport sink   (input valid, date_valid, weekday, day_number, output ready);
endinterface

`default_nettype wire

### rtl/date_check_weekday_day_number.sv
// Gregorian date check with weekday and day number.
//
// date_chan carries one request per date: year, month, day, hour, minute.
// result_chan returns one request per date, in order: date_valid, weekday
// (0 Saturday .. 6 Friday, Zeller) and day_number (EPOCH_YEAR-01-01 is 1).
// Both are zero when any field is out of range.
//
// A date taken on date_chan passes through three register stages (range
// check and /100 products, leap and sums, mod 7 and saturation) and is
// then on result_chan. Throughput: one date per cycle while result_chan
// does not stall.
// Each stage holds a valid bit and loads whenever it is empty or its
// successor takes its contents, so a stall on result_chan backs up stage by
// stage and date_chan.ready drops only once all three stages are full.
// No date is dropped or repeated during a stall.
// Reset clears the stage valid bits; the data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module date_check_weekday_day_number #(
    parameter int EPOCH_YEAR = dcwd_pkg::DEF_EPOCH_YEAR,
    parameter int LAST_YEAR  = dcwd_pkg::DEF_LAST_YEAR
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dcwd_date_if.sink      date_chan,
    dcwd_result_if.source  result_chan
);
    import dcwd_pkg::*;

    check_t chk;
    logic   chk_valid;
    logic   chk_ready;
    count_t cnt;
    logic   cnt_valid;
    logic   cnt_ready;

    // stage 1: range checks, year / 100 by reciprocal
    dcwd_check #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .date_chan (date_chan),
        .chk       (chk),
        .chk_valid (chk_valid),
        .chk_ready (chk_ready)
    );

    // stage 2: leap year, month length check, day counts, Zeller terms
    dcwd_count #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_count (
        .clk       (clk),
        .rst_n     (rst_n),
        .chk       (chk),
        .chk_valid (chk_valid),
        .chk_ready (chk_ready),
        .cnt       (cnt),
        .cnt_valid (cnt_valid),
        .cnt_ready (cnt_ready)
    );

    // stage 3: weekday, final day number, output register
    dcwd_finish u_finish (
        .clk         (clk),
        .rst_n       (rst_n),
        .cnt         (cnt),
        .cnt_valid   (cnt_valid),
        .cnt_ready   (cnt_ready),
        .result_chan (result_chan)
    );

    // invalid dates carry zero results
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && !result_chan.date_valid)
            |-> (result_chan.weekday == '0 && result_chan.day_number == '0))
        else $error("invalid date with nonzero result");

    // mod 7 never leaves 0..6
    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_chan.valid |-> (result_chan.weekday <= WDAY_W'(6)))
        else $error("weekday out of range");

    // a valid date counts from 1
    a_day_number_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_chan.valid && result_chan.date_valid) |-> (result_chan.day_number != '0))
        else $error("valid date with zero day number");

    // a date that moves on through stages 1 and 2 lands in the output register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (date_chan.valid && date_chan.ready) ##1 chk_ready ##1 cnt_ready
            |=> result_chan.valid)
        else $error("accepted date lost in pipeline");

endmodule

`default_nettype wire

### rtl/dcwd_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 1: range checks and the divide-by-100 products.
module dcwd_check #(
    parameter int EPOCH_YEAR = dcwd_pkg::DEF_EPOCH_YEAR,
    parameter int LAST_YEAR  = dcwd_pkg::DEF_LAST_YEAR
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    dcwd_date_if.sink             date_chan,
    output dcwd_pkg::check_t      chk,
    output logic                  chk_valid,
    input  wire logic             chk_ready
);
    import dcwd_pkg::*;

    logic   valid_reg;
    check_t data_reg;
    check_t data_next;
    logic   load;

    logic [YEAR_W-1:0] year_m1;

    assign date_chan.ready = !valid_reg || chk_ready;
    assign load            = date_chan.valid && date_chan.ready;

    always_comb
    begin
        year_m1 = date_chan.year_in - 12'd1;

        data_next.ok = (date_chan.year_in >= YEAR_W'(EPOCH_YEAR))
                    && (date_chan.year_in <= YEAR_W'(LAST_YEAR))
                    && (date_chan.month_in >= JAN) && (date_chan.month_in <= DEC)
                    && (date_chan.day_in != '0)
                    && (date_chan.hour_in <= HOUR_W'(MAX_HOUR))
                    && (date_chan.minute_in <= MINUTE_W'(MAX_MINUTE));
        data_next.year  = date_chan.year_in;
        data_next.month = date_chan.month_in;
        data_next.day   = date_chan.day_in;
        data_next.zy    = (date_chan.month_in < MAR) ? year_m1 : date_chan.year_in;
        data_next.yq    = CENT_W'((RECIP_100_W'(date_chan.year_in)
                                   * RECIP_100_W'(RECIP_100)) >> RECIP_100_S);
        data_next.zq    = CENT_W'((RECIP_100_W'(data_next.zy)
                                   * RECIP_100_W'(RECIP_100)) >> RECIP_100_S);
        data_next.pq    = CENT_W'((RECIP_100_W'(year_m1)
                                   * RECIP_100_W'(RECIP_100)) >> RECIP_100_S);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (date_chan.ready)
            valid_reg <= date_chan.valid;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data_next;
    end

    assign chk       = data_reg;
    assign chk_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/dcwd_count.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 2: leap year, month length, day of year, year days, Zeller sum.
module dcwd_count #(
    parameter int EPOCH_YEAR = dcwd_pkg::DEF_EPOCH_YEAR
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dcwd_pkg::check_t chk,
    input  wire logic             chk_valid,
    output logic                  chk_ready,
    output dcwd_pkg::count_t      cnt,
    output logic                  cnt_valid,
    input  wire logic             cnt_ready
);
    import dcwd_pkg::*;

    // days in whole years 1 .. EPOCH_YEAR-1
    localparam int EpochP     = EPOCH_YEAR - 1;
    localparam int EPOCH_DAYS = DAYS_YEAR * EpochP + EpochP / 4 - EpochP / 100 + EpochP / 400;

    logic   valid_reg;
    count_t data_reg;
    count_t data_next;

    logic [REM_W-1:0]  yrem;
    logic [REM_W-1:0]  k;
    logic              leap;
    logic [YEAR_W-1:0] p;
    logic [DN_W-1:0]   ydays_full;

    assign chk_ready = !valid_reg || cnt_ready;

    always_comb
    begin
        yrem = REM_W'(chk.year - YEAR_W'(chk.yq) * YEAR_W'(100));
        k    = REM_W'(chk.zy - YEAR_W'(chk.zq) * YEAR_W'(100));
        leap = ((yrem != '0) && (chk.year[1:0] == 2'b00))
            || ((yrem == '0) && (chk.yq[1:0] == 2'b00));
        p    = chk.year - 12'd1;

        ydays_full = DN_W'(p) * DN_W'(DAYS_YEAR) + DN_W'(p >> 2)
                   - DN_W'(chk.pq) + DN_W'(chk.pq >> 2) - DN_W'(EPOCH_DAYS);

        data_next.ok    = chk.ok && (chk.day <= month_len(chk.month, leap));
        data_next.doy   = DOY_W'(chk.day) + cum_days(chk.month)
                        + DOY_W'(leap && (chk.month > FEB));
        data_next.ydays = ydays_full[YDAYS_W-1:0];
        data_next.zsum  = ZSUM_W'(chk.day) + ZSUM_W'(zeller_month(chk.month))
                        + ZSUM_W'(k) + ZSUM_W'(k >> 2)
                        + ZSUM_W'(chk.zq >> 2)
                        + (ZSUM_W'(chk.zq) << 2) + ZSUM_W'(chk.zq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (chk_ready)
            valid_reg <= chk_valid;
    end

    always_ff @(posedge clk)
    begin
        if (chk_valid && chk_ready)
            data_reg <= data_next;
    end

    assign cnt       = data_reg;
    assign cnt_valid = valid_reg;

endmodule

`default_nettype wire

### rtl/dcwd_finish.sv
`timescale 1ns / 1ps
`default_nettype none

// Stage 3: weekday mod 7, day number sum and saturation, result register.
module dcwd_finish (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dcwd_pkg::count_t cnt,
    input  wire logic             cnt_valid,
    output logic                  cnt_ready,
    dcwd_result_if.source         result_chan
);
    import dcwd_pkg::*;

    logic              valid_reg;
    logic              ok_reg;
    logic [WDAY_W-1:0] wday_reg;
    logic [DNUM_W-1:0] dnum_reg;
    logic [WDAY_W-1:0] wday_next;
    logic [DNUM_W-1:0] dnum_next;

    logic [RECIP_7_W-1:0] q7_prod;
    logic [ZSUM_W-1:0]    q7;
    logic [DN_W-1:0]      dn;

    assign cnt_ready = !valid_reg || result_chan.ready;

    always_comb
    begin
        q7_prod   = RECIP_7_W'(cnt.zsum) * RECIP_7_W'(RECIP_7);
        q7        = ZSUM_W'(q7_prod >> RECIP_7_S);
        wday_next = WDAY_W'(cnt.zsum - q7 * ZSUM_W'(7));
        dn        = DN_W'(cnt.doy) + DN_W'(cnt.ydays);
        dnum_next = (dn > DN_W'({DNUM_W{1'b1}})) ? {DNUM_W{1'b1}} : dn[DNUM_W-1:0];
        if (!cnt.ok)
        begin
            wday_next = '0;
            dnum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cnt_ready)
            valid_reg <= cnt_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cnt_valid && cnt_ready)
        begin
            ok_reg   <= cnt.ok;
            wday_reg <= wday_next;
            dnum_reg <= dnum_next;
        end
    end

    assign result_chan.valid      = valid_reg;
    assign result_chan.date_valid = ok_reg;
    assign result_chan.weekday    = wday_reg;
    assign result_chan.day_number = dnum_reg;

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

// Testbench for date_check_weekday_day_number.
//
// Each date request goes through a small predictor in this file (range
// check, Gregorian leap rule, Zeller weekday with the +5J term, day count
// from 1970-01-01). The expected result is queued when the DUT accepts the
// date request. It is popped when the DUT hands back a result request.
//
// Flow:
//   - The stimulus process fills dates_to_send. The driver (negedge) pops
//     from it only if the channel is free or its request was just taken.
//   - The monitor (posedge) predicts on date acceptance and compares on
//     result acceptance, field by field.
//   - There are three flow-control profiles: an eager sender against a busy
//     receiver, then the reverse, then no idling at all. Between profiles
//     the sender holds off until every expected result is back.
//   - The watchdog ends the run if no request moves for too long.
module tb_top;
    import dcwd_pkg::*;

    localparam int FIRST_YEAR = DEF_EPOCH_YEAR;
    localparam int FINAL_YEAR = DEF_LAST_YEAR;
    localparam int RANDOM_PER_PHASE = 542;
    localparam int STALL_LIMIT = 5000;   // cycles with no request moving
    localparam int DRAIN_CYCLES = 8;     // pipeline is 3 deep

    typedef struct packed {
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } date_req_t;

    typedef struct packed {
        logic              ok;
        logic [WDAY_W-1:0] wday;
        logic [DNUM_W-1:0] dnum;
    } date_result_t;

    logic clk;
    logic rst_n;

    dcwd_date_if   date_if ();
    dcwd_result_if result_if ();

    date_check_weekday_day_number dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .date_chan   (date_if),
        .result_chan (result_if)
    );

    date_req_t    dates_to_send[$];
    date_result_t expected_results[$];

    int  send_idle_pct;    // chance per cycle that the sender holds back
    int  recv_stall_pct;   // chance per cycle that the receiver is not ready
    int  dates_taken;
    int  valid_dates;
    int  results_checked;
    int  error_count;
    int  quiet_cycles;
    logic date_taken;      // date request accepted at the last rising edge

    date_req_t    got_date;
    date_result_t want;

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------
    function automatic bit is_leap(int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
        int unsigned len;
        case (m)
            FEB:               len = is_leap(y) ? 29 : 28;
            APR, JUN, SEP, NOV: len = 30;
            default:           len = 31;
        endcase
        return len;
    endfunction

    // days in whole years 1 .. y-1
    function automatic int unsigned days_before_year(int unsigned y);
        int unsigned p;
        p = y - 1;
        return 365 * p + p / 4 - p / 100 + p / 400;
    endfunction

    function automatic date_result_t convert_date(date_req_t r);
        date_result_t res;
        int unsigned zm, zy, k, j, dn;
        bit ok;
        res = '0;
        ok = r.year >= FIRST_YEAR && r.year <= FINAL_YEAR &&
             r.month >= JAN && r.month <= DEC && r.day >= 1 &&
             r.hour <= MAX_HOUR && r.minute <= MAX_MINUTE;
        if (ok && r.day > days_in_month(r.year, r.month))
            ok = 0;
        if (ok)
        begin
            // Zeller: Jan/Feb count as months 13/14 of the previous year
            zm = r.month;
            zy = r.year;
            if (zm < MAR)
            begin
                zm += 12;
                zy -= 1;
            end
            k = zy % 100;
            j = zy / 100;
            res.wday = WDAY_W'((r.day + (13 * (zm + 1)) / 5 + k + k / 4 + j / 4 + 5 * j)
                               % 7);

            // only the months before the given one are summed
            dn = r.day;
            for (int m = JAN; m < r.month; m++)
                dn += days_in_month(r.year, m);
            dn += days_before_year(r.year) - days_before_year(FIRST_YEAR);
            res.dnum = (dn > 65535) ? 16'hFFFF : dn[15:0];
            res.ok = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_date(int y, int m, int d, int h, int mi);
        date_req_t r;
        r.year   = YEAR_W'(y);
        r.month  = MONTH_W'(m);
        r.day    = DAY_W'(d);
        r.hour   = HOUR_W'(h);
        r.minute = MINUTE_W'(mi);
        dates_to_send.push_back(r);
    endtask

    // Mostly well-formed dates, some with exactly one field out of
    // range, and a share of raw noise across the full field widths.
    task automatic add_random_date();
        date_req_t r;
        int kind;
        int len;
        kind     = $urandom_range(99);
        r.year   = YEAR_W'($urandom_range(FINAL_YEAR, FIRST_YEAR));
        r.month  = MONTH_W'($urandom_range(DEC, JAN));
        len      = int'(days_in_month(r.year, r.month));
        r.day    = DAY_W'(($urandom_range(3) == 0) ? len : $urandom_range(len, 1));
        r.hour   = HOUR_W'($urandom_range(MAX_HOUR));
        r.minute = MINUTE_W'($urandom_range(MAX_MINUTE));
        if (kind >= 70 && kind < 85)
        begin
            case ($urandom_range(4))
                0: r.year   = YEAR_W'($urandom_range(1) ? FIRST_YEAR - 1 : FINAL_YEAR + 1);
                1: r.month  = MONTH_W'($urandom_range(1) ? 0 : $urandom_range(15, 13));
                2: r.day    = DAY_W'((len < 31) ? len + 1 : 0);
                3: r.hour   = HOUR_W'($urandom_range(31, MAX_HOUR + 1));
                default: r.minute = MINUTE_W'($urandom_range(63, MAX_MINUTE + 1));
            endcase
        end
        else if (kind >= 85)
        begin
            r = $urandom;
        end
        dates_to_send.push_back(r);
    endtask

    // sender holds off until the DUT has returned everything
    task automatic wait_until_drained();
        while (dates_to_send.size() != 0 || date_if.valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: both channels change on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!date_if.valid || date_taken)
            begin
                if (dates_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    date_if.year_in   <= dates_to_send[0].year;
                    date_if.month_in  <= dates_to_send[0].month;
                    date_if.day_in    <= dates_to_send[0].day;
                    date_if.hour_in   <= dates_to_send[0].hour;
                    date_if.minute_in <= dates_to_send[0].minute;
                    date_if.valid     <= 1'b1;
                    void'(dates_to_send.pop_front());
                end
                else
                begin
                    date_if.valid <= 1'b0;
                end
            end
            result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare on result acceptance, predict on date acceptance
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        date_taken <= date_if.valid && date_if.ready;

        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_checked++;
            if (expected_results.size() == 0)
            begin
                error_count++;
                $error("result request with no date outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_if.date_valid !== want.ok)
                begin
                    error_count++;
                    $error("date_valid: expected %0d, got %0d", want.ok,
                           result_if.date_valid);
                end
                if (result_if.weekday !== want.wday)
                begin
                    error_count++;
                    $error("weekday: expected %0d, got %0d", want.wday,
                           result_if.weekday);
                end
                if (result_if.day_number !== want.dnum)
                begin
                    error_count++;
                    $error("day_number: expected %0d, got %0d", want.dnum,
                           result_if.day_number);
                end
            end
        end

        if (rst_n && date_if.valid && date_if.ready)
        begin
            got_date.year   = date_if.year_in;
            got_date.month  = date_if.month_in;
            got_date.day    = date_if.day_in;
            got_date.hour   = date_if.hour_in;
            got_date.minute = date_if.minute_in;
            want = convert_date(got_date);
            expected_results.push_back(want);
            dates_taken++;
            if (want.ok)
                valid_dates++;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no request moving on either channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (date_if.valid && date_if.ready) ||
            (result_if.valid && result_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no request moved in %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial
    begin
        date_if.valid     = 1'b0;
        date_if.year_in   = '0;
        date_if.month_in  = '0;
        date_if.day_in    = '0;
        date_if.hour_in   = '0;
        date_if.minute_in = '0;
        result_if.ready   = 1'b0;
        date_taken        = 1'b0;
        quiet_cycles      = 0;
        dates_taken       = 0;
        valid_dates       = 0;
        results_checked   = 0;
        error_count       = 0;
        send_idle_pct     = 28;
        recv_stall_pct    = 88;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: first/last day of the range, out-of-range years,
        // all-zero and all-ones fields, the three leap rules, short months,
        // month and day zero, and the hour/minute limits.
        add_date(FIRST_YEAR, JAN, 1, 0, 0);
        add_date(FINAL_YEAR, DEC, 31, 23, 59);
        add_date(FIRST_YEAR - 1, DEC, 31, 12, 30);
        add_date(FINAL_YEAR + 1, JAN, 1, 0, 0);
        add_date(0, 0, 0, 0, 0);
        add_date(4095, 15, 31, 31, 63);
        add_date(2000, FEB, 29, 6, 15);
        add_date(2024, FEB, 29, 7, 45);
        add_date(2100, FEB, 29, 8, 0);
        add_date(2100, FEB, 28, 8, 0);
        add_date(2023, FEB, 29, 9, 0);
        add_date(2023, APR, 31, 10, 0);
        add_date(2023, APR, 30, 10, 0);
        add_date(2023, 0, 10, 11, 0);
        add_date(2023, 13, 10, 11, 0);
        add_date(2023, MAY, 0, 12, 0);
        add_date(2023, JUN, 15, 23, 59);
        add_date(2023, JUN, 15, 24, 0);
        add_date(2023, JUN, 15, 31, 0);
        add_date(2023, JUN, 15, 10, 60);
        add_date(2023, JUN, 15, 10, 63);
        add_date(2000, JAN, 1, 0, 0);
        add_date(2000, MAR, 1, 0, 0);
        add_date(1972, DEC, 31, 0, 0);
        add_date(FIRST_YEAR, FEB, 28, 0, 0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 88;
                end
                1:
                begin
                    send_idle_pct  = 88;
                    recv_stall_pct = 28;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                add_random_date();
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $error("%0d expected results never arrived", expected_results.size());
        end

        $display("Sent %0d dates (%0d valid), checked %0d results", dates_taken,
                 valid_dates, results_checked);
        $display("Covered field extremes, leap rules and three flow-control profiles");
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
